/* sv/dmhk_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the direct-mapped hash key cache: field widths,
// command codes and the lowbias32 hash constants. No dependencies.
package dmhk_pkg;

    localparam int MAX_SLOTS_DEF = 1024;

    localparam int CMD_W  = 3;
    localparam int KEY_W  = 32;
    localparam int SIDX_W = 10;
    localparam int CNT_W  = 11;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_VALID    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP      = 3'd4;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

    localparam logic [KEY_W-1:0] HASH_MUL1 = 32'h7feb352d;
    localparam logic [KEY_W-1:0] HASH_MUL2 = 32'h846ca68d;
    localparam int HASH_SHIFT_A = 16;
    localparam int HASH_SHIFT_B = 15;

endpackage

/* sv/direct_mapped_hash_key_cache.sv */
`timescale 1ns / 1ps
// Add, contains and remove go from acceptance to result by two passes
// through one shared 32x32 multiplier, a mix step, a 32-step restoring
// remainder against the slot count, a memory read and an update. Slot valid
// queries, pops and unknown commands take only the memory read and the update.
// One transaction is in work at a time; the output register lets the next one
// be accepted while a result waits. After reset the slot memory is cleared,
// one entry a cycle, before the first transaction is accepted.
//
// Top level of the direct-mapped hash key cache. Depends on dmhk_pkg.
module direct_mapped_hash_key_cache #(
    parameter int MAX_SLOTS = dmhk_pkg::MAX_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmhk_pkg::ADDR_W-1:0]         paddr,
    input  logic [dmhk_pkg::DATA_W-1:0]         pwdata,
    output logic [dmhk_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    // Command channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dmhk_pkg::CMD_W-1:0]          command,
    input  logic signed [dmhk_pkg::KEY_W-1:0]   key,
    input  logic [dmhk_pkg::SIDX_W-1:0]         slot_index,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                flag,
    output logic signed [dmhk_pkg::KEY_W-1:0]   value
);
    import dmhk_pkg::*;

    // Slot address width and the width that holds the slot count in use.
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MIX,
        ST_DIV,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    x_reg, x_next;
    logic [NW-1:0]       rem_reg, rem_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                in_range_reg, in_range_next;
    logic                occ0_reg, occ0_next;
    logic [CNT_W-1:0]    slot_count_reg;
    logic                out_valid_reg, out_valid_next;
    logic                flag_reg, flag_next;
    logic [KEY_W-1:0]    value_reg, value_next;
    logic [KEY_W-1:0]    rd_data_reg;

    // Slot memory, written at one port and read at one port.
    logic [KEY_W-1:0]    mem [MAX_SLOTS];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_W-1:0]    mem_wdata;
    logic                mem_re;

    // Slot count in use: zero reads as one and counts above the store size
    // are held at the store size.
    logic [31:0]         n_full;
    logic [NW-1:0]       n_use;

    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            n_full = 32'd1;
        end
        else if (32'(slot_count_reg) > 32'(MAX_SLOTS))
        begin
            n_full = 32'(MAX_SLOTS);
        end
        else
        begin
            n_full = 32'(slot_count_reg);
        end
    end
    assign n_use = NW'(n_full);

    // Configuration register. Register 0 sits at byte address 0; a write to
    // any other word is ignored.
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? DATA_W'(slot_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
        end
        else if (cfg_wr && (paddr[2] == 1'b0))
        begin
            slot_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // The one multiplier, shared by both hash rounds. Each round folds the
    // preceding xor-shift into its operand.
    logic [KEY_W-1:0] mul_a, mul_b, mul_p;

    always_comb
    begin
        if (state_reg == ST_MUL2)
        begin
            mul_a = x_reg ^ (x_reg >> HASH_SHIFT_B);
            mul_b = HASH_MUL2;
        end
        else
        begin
            mul_a = x_reg ^ (x_reg >> HASH_SHIFT_A);
            mul_b = HASH_MUL1;
        end
    end
    assign mul_p = mul_a * mul_b;

    // One restoring remainder step: shift in the next hash bit and subtract
    // the slot count when it fits.
    logic [NW:0] trial, rem_sub;
    assign trial   = {rem_reg, x_reg[KEY_W-1]};
    assign rem_sub = (trial >= {1'b0, n_use}) ? (trial - {1'b0, n_use}) : trial;

    // Result of the current transaction and the memory update it causes.
    logic            hit_zero;
    logic            rd_nz;
    logic            res_flag;
    logic [KEY_W-1:0] res_value;
    logic            res_we;
    logic [KEY_W-1:0] res_wdata;
    logic            res_occ0;

    assign hit_zero = (slot_reg == '0);
    assign rd_nz    = (rd_data_reg != '0);

    always_comb
    begin
        res_flag  = 1'b0;
        res_value = '0;
        res_we    = 1'b0;
        res_wdata = '0;
        res_occ0  = occ0_reg;
        case (cmd_reg)
            CMD_ADD:
            begin
                // Slot 0 uses its own flag; other slots are empty when zero.
                if (hit_zero)
                begin
                    res_flag  = occ0_reg;
                    res_value = occ0_reg ? rd_data_reg : '0;
                    res_occ0  = 1'b1;
                end
                else
                begin
                    res_flag  = rd_nz;
                    res_value = rd_data_reg;
                end
                res_we    = 1'b1;
                res_wdata = key_reg;
            end
            CMD_CONTAINS:
            begin
                res_flag = (hit_zero ? occ0_reg : rd_nz) && (rd_data_reg == key_reg);
            end
            CMD_REMOVE:
            begin
                if (rd_data_reg == key_reg)
                begin
                    if (hit_zero)
                    begin
                        res_flag = occ0_reg;
                        res_occ0 = 1'b0;
                    end
                    else if (rd_nz)
                    begin
                        res_flag = 1'b1;
                        res_we   = 1'b1;
                    end
                end
            end
            CMD_VALID:
            begin
                if (in_range_reg)
                begin
                    res_flag = hit_zero ? occ0_reg : rd_nz;
                end
            end
            CMD_POP:
            begin
                // Popping slot 0 drops only its flag and keeps the word.
                if (in_range_reg)
                begin
                    res_value = rd_data_reg;
                    if (hit_zero)
                    begin
                        res_occ0 = 1'b0;
                    end
                    else
                    begin
                        res_we = 1'b1;
                    end
                end
            end
            default:
            begin
                res_flag = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        x_next         = x_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        in_range_next  = in_range_reg;
        occ0_next      = occ0_reg;
        out_valid_next = out_valid_reg;
        flag_next      = flag_reg;
        value_next     = value_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = res_wdata;
        mem_re         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = command;
                    key_next      = key;
                    x_next        = key;
                    in_range_next = (32'(slot_index) < n_full);
                    slot_next     = AW'(32'(slot_index));
                    if (command == CMD_ADD || command == CMD_CONTAINS ||
                        command == CMD_REMOVE)
                    begin
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_MUL1:
            begin
                x_next     = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                x_next     = mul_p;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                x_next     = x_reg ^ (x_reg >> HASH_SHIFT_A);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = NW'(rem_sub);
                x_next   = {x_reg[KEY_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    slot_next  = AW'(rem_sub);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    mem_we         = res_we;
                    occ0_next      = res_occ0;
                    flag_next      = res_flag;
                    value_next     = res_value;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            occ0_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            occ0_reg      <= occ0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        x_reg        <= x_next;
        rem_reg      <= rem_next;
        slot_reg     <= slot_next;
        in_range_reg <= in_range_next;
        flag_reg     <= flag_next;
        value_reg    <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign flag      = flag_reg;
    assign value     = $signed(value_reg);

`ifndef SYNTH
    // The input is never ready right after a transaction is taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while busy");

    // The memory is only written by the clearing pass or the update step.
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_EXEC))
        else $error("slot memory written outside clear or update");

    // The partial remainder stays below the slot count in use while that count is not rewritten.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < n_use))
        else $error("remainder reached the slot count");

    // A result appears only out of the update step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised outside the update step");
`endif

endmodule
